FILE: rtl/core/wis_pkg.sv
// ----------------------------------------------------------------------------
// wis_pkg: shared definitions of the weighted index sampler
// Types, codes and sizes used by the sampler's table, sequencer and top level.
// ----------------------------------------------------------------------------
package wis_pkg;

  localparam int Entries        = 1024;
  localparam int BisectionSteps = 10;

  localparam int IdxW  = 10;
  localparam int ValW  = 32;
  localparam int AddrW = $clog2(Entries);
  localparam int StepW = $clog2(BisectionSteps + 2);

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } wis_req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_REVERSED = 2'd1,
    STATUS_NONE     = 2'd2
  } wis_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_LAST,
    ST_SPAN,
    ST_TGT,
    ST_BIS,
    ST_BIS_CMP,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_OUT
  } wis_state_e;

  typedef struct packed {
    wis_req_type_e    req_type;
    logic [IdxW-1:0]  entry_index;
    logic [ValW-1:0]  entry_value;
    logic [IdxW-1:0]  range_first;
    logic [IdxW-1:0]  range_last;
    logic [ValW-1:0]  uniform;
  } wis_req_t;

  typedef struct packed {
    logic [IdxW-1:0] chosen_index;
    wis_status_e     status;
  } wis_res_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] value;
  } wis_wr_t;

endpackage

FILE: rtl/core/wis_table.sv
// ----------------------------------------------------------------------------
// wis_table: cumulative weight table
// Single-port-write, single-port-read memory with a registered read. Positions
// beyond the table are ignored on write and read as zero.
// ----------------------------------------------------------------------------
module wis_table (
  input  logic                      clk_i,
  input  wis_pkg::wis_wr_t          wr_i,
  input  logic [wis_pkg::IdxW-1:0]  rd_idx_i,
  output logic [wis_pkg::ValW-1:0]  rd_data_o
);

  logic [wis_pkg::ValW-1:0]  mem [wis_pkg::Entries];
  logic [wis_pkg::ValW-1:0]  rd_data_q;
  logic                      rd_ok_q;
  logic [wis_pkg::AddrW-1:0] wr_addr;
  logic [wis_pkg::AddrW-1:0] rd_addr;
  logic                      wr_ok;
  logic                      rd_ok;

  assign wr_addr = wis_pkg::AddrW'(wr_i.idx);
  assign rd_addr = wis_pkg::AddrW'(rd_idx_i);
  assign wr_ok   = 32'(wr_i.idx) < 32'(wis_pkg::Entries);
  assign rd_ok   = 32'(rd_idx_i) < 32'(wis_pkg::Entries);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_ok) begin
      mem[wr_addr] <= wr_i.value;
    end
    rd_data_q <= mem[rd_addr];
    rd_ok_q   <= rd_ok;
  end

  assign rd_data_o = rd_ok_q ? rd_data_q : '0;

endmodule

FILE: rtl/core/wis_mul.sv
// ----------------------------------------------------------------------------
// wis_mul: registered 32 by 32 multiplier
// Forms the full product of two unsigned words and presents its upper half
// in the next cycle.
// ----------------------------------------------------------------------------
module wis_mul (
  input  logic                     clk_i,
  input  logic [wis_pkg::ValW-1:0] a_i,
  input  logic [wis_pkg::ValW-1:0] b_i,
  output logic [wis_pkg::ValW-1:0] hi_o
);

  logic [2*wis_pkg::ValW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= (2*wis_pkg::ValW)'(a_i) * (2*wis_pkg::ValW)'(b_i);
  end

  assign hi_o = prod_q[2*wis_pkg::ValW-1:wis_pkg::ValW];

endmodule

FILE: rtl/core/wis_seq.sv
// ----------------------------------------------------------------------------
// wis_seq: sampling sequencer
// Reads the range bounds, forms the target through the registered multiplier and
// walks the table with one compare per step: bisection first, then a scan.
// ----------------------------------------------------------------------------
module wis_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  wis_pkg::wis_req_t         req_i,
  output logic                      busy_o,
  output logic                      valid_o,
  output wis_pkg::wis_res_t         res_o,
  output wis_pkg::wis_wr_t          wr_o,
  output logic [wis_pkg::IdxW-1:0]  rd_idx_o,
  input  logic [wis_pkg::ValW-1:0]  rd_data_i,
  output logic [wis_pkg::ValW-1:0]  mul_a_o,
  output logic [wis_pkg::ValW-1:0]  mul_b_o,
  input  logic [wis_pkg::ValW-1:0]  mul_hi_i
);

  wis_pkg::wis_state_e       state_q, state_d;
  logic [wis_pkg::IdxW-1:0]  first_q, first_d;
  logic [wis_pkg::IdxW-1:0]  hi_q, hi_d;
  logic [wis_pkg::IdxW:0]    lo_q, lo_d;
  logic [wis_pkg::IdxW-1:0]  mid_q, mid_d;
  logic [wis_pkg::ValW-1:0]  u_q, u_d;
  logic [wis_pkg::ValW-1:0]  base_q, base_d;
  logic [wis_pkg::ValW-1:0]  target_q, target_d;
  logic [wis_pkg::StepW-1:0] step_q, step_d;
  wis_pkg::wis_res_t         res_q, res_d;
  logic [wis_pkg::IdxW+1:0]  mid_sum;
  logic                      hit;
  logic                      accept;

  assign accept  = start_i && (state_q == wis_pkg::ST_IDLE);
  assign mid_sum = (wis_pkg::IdxW+2)'(lo_q) + (wis_pkg::IdxW+2)'(hi_q);
  assign hit     = target_q <= rd_data_i;

  assign wr_o.en    = accept && (req_i.req_type == wis_pkg::REQ_WRITE);
  assign wr_o.idx   = req_i.entry_index;
  assign wr_o.value = req_i.entry_value;

  assign mul_a_o = u_q;
  assign mul_b_o = rd_data_i - base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wis_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    mid_q    <= mid_d;
    u_q      <= u_d;
    base_q   <= base_d;
    target_q <= target_d;
    step_q   <= step_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d  = state_q;
    first_d  = first_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    mid_d    = mid_q;
    u_d      = u_q;
    base_d   = base_q;
    target_d = target_q;
    step_d   = step_q;
    res_d    = res_q;
    rd_idx_o = mid_q;
    case (state_q)
      wis_pkg::ST_IDLE: begin
        if (accept && (req_i.req_type == wis_pkg::REQ_SAMPLE)) begin
          first_d = req_i.range_first;
          hi_d    = req_i.range_last;
          lo_d    = {1'b0, req_i.range_first};
          u_d     = req_i.uniform;
          step_d  = '0;
          if (req_i.range_first > req_i.range_last) begin
            res_d.chosen_index = '0;
            res_d.status       = wis_pkg::STATUS_REVERSED;
            state_d            = wis_pkg::ST_OUT;
          end else begin
            state_d = wis_pkg::ST_BASE;
          end
        end
      end
      wis_pkg::ST_BASE: begin
        rd_idx_o = first_q - 1'b1;
        state_d  = wis_pkg::ST_LAST;
      end
      wis_pkg::ST_LAST: begin
        rd_idx_o = hi_q;
        base_d   = (first_q == '0) ? '0 : rd_data_i;
        state_d  = wis_pkg::ST_SPAN;
      end
      wis_pkg::ST_SPAN: begin
        state_d = wis_pkg::ST_TGT;
      end
      wis_pkg::ST_TGT: begin
        target_d = base_q + mul_hi_i;
        state_d  = (wis_pkg::BisectionSteps > 0) ? wis_pkg::ST_BIS : wis_pkg::ST_SCAN;
      end
      wis_pkg::ST_BIS: begin
        mid_d    = mid_sum[wis_pkg::IdxW:1];
        rd_idx_o = mid_sum[wis_pkg::IdxW:1];
        state_d  = wis_pkg::ST_BIS_CMP;
      end
      wis_pkg::ST_BIS_CMP: begin
        if (hit) begin
          hi_d = mid_q;
        end else begin
          lo_d = (wis_pkg::IdxW+1)'(mid_q) + 1'b1;
        end
        step_d = step_q + 1'b1;
        if (int'(step_q) + 1 >= wis_pkg::BisectionSteps) begin
          state_d = wis_pkg::ST_SCAN;
        end else begin
          state_d = wis_pkg::ST_BIS;
        end
      end
      wis_pkg::ST_SCAN: begin
        rd_idx_o = lo_q[wis_pkg::IdxW-1:0];
        if (lo_q > (wis_pkg::IdxW+1)'(hi_q)) begin
          res_d.chosen_index = '0;
          res_d.status       = wis_pkg::STATUS_NONE;
          state_d            = wis_pkg::ST_OUT;
        end else begin
          state_d = wis_pkg::ST_SCAN_CMP;
        end
      end
      wis_pkg::ST_SCAN_CMP: begin
        if (hit) begin
          res_d.chosen_index = lo_q[wis_pkg::IdxW-1:0];
          res_d.status       = wis_pkg::STATUS_OK;
          state_d            = wis_pkg::ST_OUT;
        end else begin
          lo_d    = lo_q + 1'b1;
          state_d = wis_pkg::ST_SCAN;
        end
      end
      wis_pkg::ST_OUT: begin
        state_d = wis_pkg::ST_IDLE;
      end
      default: begin
        state_d = wis_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o  = state_q != wis_pkg::ST_IDLE;
  assign valid_o = state_q == wis_pkg::ST_OUT;
  assign res_o   = res_q;

endmodule

FILE: rtl/core/weighted_index_sampler_core.sv
// ----------------------------------------------------------------------------
// weighted_index_sampler_core: inverse-CDF weighted index sampler
// Loads a table of cumulative weights and draws indices by binary search and a scan.
// ----------------------------------------------------------------------------
// A request beat is taken on a rising edge with start high and busy low.
// A write beat stores entry_value at entry_index in the same edge, gives no
// result and leaves the block free for a new beat in the next cycle.
// A sample beat raises busy until its result beat has been shown. The result
// is on res_o for exactly one cycle with valid_o high; the receiver cannot
// stall it. A reversed range gives its result beat in the cycle right after
// the request beat, and the next beat can be taken in the cycle after the
// result beat. Otherwise the sequencer reads both range bounds, forms the
// target through the registered multiplier, then runs ten bisection steps and
// a short ascending scan, each step one read of the table's registered port
// and one compare. The next beat can be taken in the cycle after the result
// beat; the reads depend on one another and go through the single table read
// port.
// Reset returns the sequencer to idle; the table is not cleared and an entry
// must be written before a sample reads it.
// ----------------------------------------------------------------------------
module weighted_index_sampler_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  wis_pkg::wis_req_t  req_i,
  output logic               busy,
  output logic               valid_o,
  output wis_pkg::wis_res_t  res_o
);

  wis_pkg::wis_wr_t          wr;
  logic [wis_pkg::IdxW-1:0]  rd_idx;
  logic [wis_pkg::ValW-1:0]  rd_data;
  logic [wis_pkg::ValW-1:0]  mul_a;
  logic [wis_pkg::ValW-1:0]  mul_b;
  logic [wis_pkg::ValW-1:0]  mul_hi;

  wis_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .busy_o    (busy),
    .valid_o   (valid_o),
    .res_o     (res_o),
    .wr_o      (wr),
    .rd_idx_o  (rd_idx),
    .rd_data_i (rd_data),
    .mul_a_o   (mul_a),
    .mul_b_o   (mul_b),
    .mul_hi_i  (mul_hi)
  );

  wis_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  wis_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .hi_o  (mul_hi)
  );

  a_result_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("Result beat shown while the sequencer is idle.");

  a_free_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy && !valid_o)
    else $error("Sequencer did not return to idle after a result beat.");

  a_sample_starts_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.req_type == wis_pkg::REQ_SAMPLE) |=> busy)
    else $error("Sample beat was taken but the sequencer did not start.");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.req_type == wis_pkg::REQ_WRITE) |=> !busy && !valid_o)
    else $error("Write beat caused work or a result.");

  a_failed_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (res_o.status != wis_pkg::STATUS_OK) |-> res_o.chosen_index == '0)
    else $error("Failed sample carries a non-zero index.");

endmodule

FILE: bench/weighted_index_sampler_core_tb.sv
// ----------------------------------------------------------------------------
// weighted_index_sampler_core_tb: self-checking bench of the weighted index sampler
// Loads cumulative weights, draws samples over checked index ranges and compares
// every result beat with an inverse-CDF search kept in the bench, under several
// patterns of sender idling.
// ----------------------------------------------------------------------------
module weighted_index_sampler_core_tb;

  localparam int          WatchdogLimit = 4000;
  localparam int          SettleCycles  = 64;
  localparam int          PhaseBeats    = 435;
  localparam logic [31:0] WeightStep    = 32'h0040_0000;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  wis_pkg::wis_req_t req_i   = '0;
  logic              busy;
  logic              valid_o;
  wis_pkg::wis_res_t res_o;

  wis_pkg::wis_req_t req_pending[$];
  wis_pkg::wis_res_t res_expected[$];
  logic [31:0] weights [wis_pkg::Entries];
  bit          filled [wis_pkg::Entries];
  int unsigned idle_pct     = 0;
  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned error_count  = 0;
  bit          req_taken    = 1'b0;

  weighted_index_sampler_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .busy    (busy),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic wis_pkg::wis_res_t draw_index(wis_pkg::wis_req_t r);
    logic [31:0] base_w;
    logic [31:0] span_w;
    logic [31:0] target_w;
    logic [63:0] prod;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned k;
    wis_pkg::wis_res_t res;
    res.chosen_index = '0;
    res.status       = wis_pkg::STATUS_NONE;
    if (r.range_first > r.range_last) begin
      res.status = wis_pkg::STATUS_REVERSED;
      return res;
    end
    base_w   = (r.range_first == 0) ? 32'd0 : weights[r.range_first - 1];
    span_w   = weights[r.range_last] - base_w;
    prod     = {32'd0, r.uniform} * {32'd0, span_w};
    target_w = base_w + prod[63:32];
    lo = r.range_first;
    hi = r.range_last;
    repeat (wis_pkg::BisectionSteps) begin
      mid = (lo + hi) >> 1;
      if (target_w <= weights[mid]) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    for (k = lo; k <= hi; k++) begin
      if (target_w <= weights[k]) begin
        res.chosen_index = wis_pkg::IdxW'(k);
        res.status       = wis_pkg::STATUS_OK;
        return res;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_write(int unsigned idx, logic [31:0] value);
    wis_pkg::wis_req_t r;
    r.req_type    = wis_pkg::REQ_WRITE;
    r.entry_index = wis_pkg::IdxW'(idx);
    r.entry_value = value;
    r.range_first = wis_pkg::IdxW'($urandom);
    r.range_last  = wis_pkg::IdxW'($urandom);
    r.uniform     = $urandom;
    filled[idx] = 1'b1;
    req_pending.push_back(r);
    beats_queued++;
  endtask

  task automatic queue_sample(int unsigned first, int unsigned last, logic [31:0] u);
    wis_pkg::wis_req_t r;
    r.req_type    = wis_pkg::REQ_SAMPLE;
    r.entry_index = wis_pkg::IdxW'($urandom);
    r.entry_value = $urandom;
    r.range_first = wis_pkg::IdxW'(first);
    r.range_last  = wis_pkg::IdxW'(last);
    r.uniform     = u;
    req_pending.push_back(r);
    beats_queued++;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (req_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        req_i <= req_pending.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    wis_pkg::wis_res_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (valid_o) begin
        if (res_expected.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: index %0d status %0d",
                                    res_o.chosen_index, res_o.status));
        end else begin
          want = res_expected.pop_front();
          if (res_o.chosen_index !== want.chosen_index) begin
            report_mismatch($sformatf("chosen_index %0d, expected %0d",
                                      res_o.chosen_index, want.chosen_index));
          end
          if (res_o.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", res_o.status, want.status));
          end
        end
      end
      req_taken <= start && !busy;
      if (start && !busy) begin
        beats_taken++;
        if (req_i.req_type == wis_pkg::REQ_WRITE) begin
          weights[req_i.entry_index] = req_i.entry_value;
        end else begin
          res_expected.push_back(draw_index(req_i));
        end
      end
      if (valid_o || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("weighted_index_sampler_core_tb: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned seg_len;
    int unsigned fill_ptr;
    int unsigned last_fill;
    int unsigned first;
    int unsigned last;
    int unsigned width;
    int unsigned tries;
    int unsigned k;
    logic [31:0] u;
    bit          ready;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Flat weights, a full-scale entry and a drop after it, so that the wrapped
    // span and the no-index case are both reached.
    queue_write(0, 32'd0);
    queue_write(1, 32'd100);
    queue_write(2, 32'd100);
    queue_write(3, 32'hFFFF_FFFF);
    queue_write(4, 32'd50);
    queue_write(1021, 32'd5);
    queue_write(1022, 32'h8000_0000);
    queue_write(1023, 32'hFFFF_FFFF);
    queue_sample(0, 0, 32'd0);
    queue_sample(0, 3, 32'hFFFF_FFFF);
    queue_sample(1, 3, 32'h8000_0000);
    queue_sample(1, 2, $urandom);
    queue_sample(3, 3, 32'hFFFF_FFFF);
    queue_sample(4, 4, 32'd0);
    queue_sample(4, 4, 32'hFFFF_FFFF);
    queue_sample(0, 4, 32'h4000_0000);
    queue_sample(1022, 1023, 32'hFFFF_FFFF);
    queue_sample(1022, 1022, 32'd0);
    queue_sample(1023, 0, $urandom);
    queue_sample(5, 4, $urandom);

    fill_ptr  = 0;
    last_fill = 0;
    for (phase = 0; phase < 4; phase++) begin
      // The receiver cannot hold results off, so only the sender's share of
      // each idling pattern is applied.
      case (phase)
        1: idle_pct = 71;
        3: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      phase_end = beats_queued + PhaseBeats;
      while (beats_queued < phase_end) begin
        seg_len = $urandom_range(16, 2);
        repeat (seg_len) begin
          if ($urandom_range(15) == 0) begin
            queue_write($urandom_range(wis_pkg::Entries - 1), $urandom);
          end else begin
            queue_write(fill_ptr, fill_ptr * WeightStep + $urandom_range(WeightStep - 1));
            last_fill = fill_ptr;
            fill_ptr  = (fill_ptr + 1) % wis_pkg::Entries;
          end
        end
        repeat ($urandom_range(8, 2)) begin
          case ($urandom_range(7))
            0: u = '0;
            1: u = '1;
            default: u = $urandom;
          endcase
          if ($urandom_range(11) == 0) begin
            first = $urandom_range(wis_pkg::Entries - 1, 1);
            last  = $urandom_range(first - 1);
          end else begin
            ready = 1'b0;
            for (tries = 0; tries < 8 && !ready; tries++) begin
              case ($urandom_range(2))
                0: width = $urandom_range(7);
                1: width = $urandom_range(63);
                default: width = $urandom_range(wis_pkg::Entries - 1);
              endcase
              first = $urandom_range(wis_pkg::Entries - 1);
              last  = (first + width > wis_pkg::Entries - 1) ? wis_pkg::Entries - 1
                                                             : first + width;
              ready = 1'b1;
              for (k = (first > 0) ? first - 1 : 0; k <= last; k++) begin
                if (!filled[k]) ready = 1'b0;
              end
            end
            if (!ready) begin
              last  = last_fill;
              first = last_fill - $urandom_range((last_fill < 16) ? last_fill : 16);
            end
          end
          queue_sample(first, last, u);
        end
      end
      while (beats_taken != beats_queued || res_expected.size() != 0) @(posedge clk_i);
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("weighted_index_sampler_core_tb: clean");
    end else begin
      $display("weighted_index_sampler_core_tb: errors");
    end
    $finish;
  end

endmodule
